>>> rtl/plsfa_pkg.sv
// Shared constants, types and helpers for the power-law spring force accumulator.
package plsfa_pkg;

    localparam int PARTICLE_COUNT = 1024;
    localparam int ADDR_W         = $clog2(PARTICLE_COUNT);
    localparam int IDX_W          = 10;
    localparam int POS_W          = 32;
    localparam int FORCE_W        = 48;
    localparam int ACC_W          = 3 * FORCE_W;
    localparam int IN_DATA_W      = 280;
    localparam int OUT_DATA_W     = 152;
    localparam int ONE_Q16        = 65536;

    localparam logic [1:0] LAW_INVALID = 2'd0;
    localparam logic [1:0] LAW_RECIP   = 2'd1;
    localparam logic [1:0] LAW_SQUARE  = 2'd2;
    localparam logic [1:0] LAW_QUART   = 2'd3;

    localparam logic [46:0] MAXMAG   = {47{1'b1}};
    localparam logic [47:0] MAX_ACC  = {1'b0, {47{1'b1}}};
    localparam logic [47:0] MIN_ACC  = {1'b1, {47{1'b0}}};

    localparam logic [5:0] MUL_LAST  = 6'd3;
    localparam logic [5:0] ROOT_LAST = 6'd32;
    localparam logic [5:0] DIV_LAST  = 6'd49;

    typedef enum logic [2:0] {
        OP_SQ,
        OP_ROOT,
        OP_DIV,
        OP_Q2,
        OP_Q4,
        OP_KM,
        OP_FM
    } op_t;

    typedef struct packed {
        logic       load;
        logic       start;
        op_t        op;
        logic [1:0] axis;
        logic       zero_flag;
        logic       fac;
        logic       acc_sel_second;
        logic       acc_upd;
        logic       acc_read_clr;
        logic       clr;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       action;
        logic       done;
        logic       zero;
        logic [1:0] law;
        logic       clr_last;
        logic       out_free;
    } dp_status_t;

    function automatic logic [48:0] sat_add48(logic signed [47:0] a, logic signed [47:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47])
        begin
            return {1'b1, (s[48] ? MIN_ACC : MAX_ACC)};
        end
        return {1'b0, s[47:0]};
    endfunction

endpackage

>>> rtl/plsfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plsfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/plsfa_ctrl.sv
// Controller state machine sequencing the spring force datapath.
module plsfa_ctrl import plsfa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_SQ,
        ST_CHECK,
        ST_ROOT,
        ST_DIV,
        ST_Q2,
        ST_Q4,
        ST_FAC,
        ST_KM,
        ST_FM,
        ST_RD1,
        ST_UP1,
        ST_RD2,
        ST_UP2,
        ST_RDR,
        ST_RCL,
        ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic       start_reg, start_next;
    logic [1:0] axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            start_reg <= 1'b0;
            axis_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            axis_reg  <= axis_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        start_next         = 1'b0;
        axis_next          = axis_reg;
        cmd                = '0;
        cmd.start          = start_reg;
        cmd.axis           = axis_reg;
        cmd.op             = OP_SQ;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    axis_next = 2'd0;
                    if (status.action)
                    begin
                        state_next = ST_RDR;
                    end
                    else
                    begin
                        state_next = ST_SQ;
                        start_next = 1'b1;
                    end
                end
            end
            ST_SQ:
            begin
                cmd.op = OP_SQ;
                if (status.done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        axis_next  = 2'd0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        start_next = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.zero)
                begin
                    cmd.zero_flag = 1'b1;
                    state_next    = ST_OUT;
                end
                else
                begin
                    state_next = ST_ROOT;
                    start_next = 1'b1;
                end
            end
            ST_ROOT:
            begin
                cmd.op = OP_ROOT;
                if (status.done)
                begin
                    state_next = ST_DIV;
                    start_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.done)
                begin
                    if (status.law == LAW_RECIP)
                    begin
                        state_next = ST_FAC;
                    end
                    else
                    begin
                        state_next = ST_Q2;
                        start_next = 1'b1;
                    end
                end
            end
            ST_Q2:
            begin
                cmd.op = OP_Q2;
                if (status.done)
                begin
                    if (status.law == LAW_QUART)
                    begin
                        state_next = ST_Q4;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FAC;
                    end
                end
            end
            ST_Q4:
            begin
                cmd.op = OP_Q4;
                if (status.done)
                begin
                    state_next = ST_FAC;
                end
            end
            ST_FAC:
            begin
                cmd.fac    = 1'b1;
                axis_next  = 2'd0;
                state_next = ST_KM;
                start_next = 1'b1;
            end
            ST_KM:
            begin
                cmd.op = OP_KM;
                if (status.done)
                begin
                    state_next = ST_FM;
                    start_next = 1'b1;
                end
            end
            ST_FM:
            begin
                cmd.op = OP_FM;
                if (status.done)
                begin
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_RD1;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_KM;
                        start_next = 1'b1;
                    end
                end
            end
            ST_RD1:
            begin
                state_next = ST_UP1;
            end
            ST_UP1:
            begin
                cmd.acc_upd = 1'b1;
                state_next  = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.acc_sel_second = 1'b1;
                state_next         = ST_UP2;
            end
            ST_UP2:
            begin
                cmd.acc_sel_second = 1'b1;
                cmd.acc_upd        = 1'b1;
                state_next         = ST_OUT;
            end
            ST_RDR:
            begin
                state_next = ST_RCL;
            end
            ST_RCL:
            begin
                cmd.acc_read_clr = 1'b1;
                state_next       = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/plsfa_datapath.sv
// Datapath: operand registers, shared multiplier, divide/root unit, accumulators, output register.
module plsfa_datapath import plsfa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_action,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [IDX_W-1:0] in_idx1, in_idx2;
    logic [POS_W-1:0] in_pos1 [3];
    logic [POS_W-1:0] in_pos2 [3];
    logic [31:0]      in_k, in_l0;
    logic signed [32:0] diff [3];
    logic [32:0]        diff_mag [3];

    logic [IDX_W-1:0]  idx1_reg, idx2_reg;
    logic [31:0]       k_reg, l0_reg;
    logic [32:0]       mag_reg [3];
    logic [2:0]        dneg_reg;
    logic [49:0]       norm2_reg;
    logic [33:0]       n_reg;
    logic [46:0]       q_reg, q2_reg, q4_reg, km_reg;
    logic [47:0]       fm_reg;
    logic              fneg_reg;
    logic signed [47:0] force_reg [3];

    logic [1:0]  law_reg;
    logic        flag_reg;
    logic        busy_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] ma_reg, mb_reg;
    logic [95:0] prod_reg;
    logic [65:0] sh_reg;
    logic [37:0] rem_reg;
    logic [49:0] res_reg;
    logic [33:0] den_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic        out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic        is_mul;
    logic [47:0] op_a, op_b;
    logic [5:0]  last_cnt;
    logic [23:0] a_part, b_part;
    logic [47:0] pp;
    logic [95:0] pp_shift;
    logic [37:0] r_rem, r_trial;
    logic [37:0] d_rem;
    logic        d_ge;
    logic        p_sat, d_sat;
    logic [46:0] m_res;
    logic signed [48:0] fac;

    logic [IDX_W-1:0]  sel_idx;
    logic              in_range;
    logic [ACC_W-1:0]  rd_data, wr_data, upd_data;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic [2:0]        upd_sat;
    logic [48:0]       add_res [3];
    logic signed [47:0] add_val [3];

    assign in_idx1    = in_data[9:0];
    assign in_idx2    = in_data[19:10];
    assign in_pos1[0] = in_data[51:20];
    assign in_pos1[1] = in_data[83:52];
    assign in_pos1[2] = in_data[115:84];
    assign in_pos2[0] = in_data[147:116];
    assign in_pos2[1] = in_data[179:148];
    assign in_pos2[2] = in_data[211:180];
    assign in_k       = in_data[243:212];
    assign in_l0      = in_data[275:244];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a]     = $signed({in_pos2[a][31], in_pos2[a]})
                        - $signed({in_pos1[a][31], in_pos1[a]});
            diff_mag[a] = diff[a][32] ? 33'(-diff[a]) : 33'(diff[a]);
        end
    end

    assign is_mul = (cmd.op != OP_ROOT) && (cmd.op != OP_DIV);

    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        last_cnt = MUL_LAST;
        unique case (cmd.op)
            OP_SQ:
            begin
                op_a = 48'(mag_reg[cmd.axis]);
                op_b = 48'(mag_reg[cmd.axis]);
            end
            OP_ROOT:
            begin
                last_cnt = ROOT_LAST;
            end
            OP_DIV:
            begin
                last_cnt = DIV_LAST;
            end
            OP_Q2:
            begin
                op_a = 48'(q_reg);
                op_b = 48'(q_reg);
            end
            OP_Q4:
            begin
                op_a = 48'(q2_reg);
                op_b = 48'(q2_reg);
            end
            OP_KM:
            begin
                op_a = 48'(k_reg);
                op_b = 48'(mag_reg[cmd.axis]);
            end
            OP_FM:
            begin
                op_a = 48'(km_reg);
                op_b = fm_reg;
            end
            default:
            begin
                last_cnt = MUL_LAST;
            end
        endcase
    end

    assign a_part = cnt_reg[0] ? ma_reg[47:24] : ma_reg[23:0];
    assign b_part = cnt_reg[1] ? mb_reg[47:24] : mb_reg[23:0];
    assign pp     = 48'(a_part) * 48'(b_part);

    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    pp_shift = 96'(pp);
            2'd3:    pp_shift = {pp, 48'd0};
            default: pp_shift = {24'd0, pp, 24'd0};
        endcase
    end

    assign r_rem   = {rem_reg[35:0], sh_reg[65:64]};
    assign r_trial = {res_reg[35:0], 2'b01};
    assign d_rem   = {rem_reg[36:0], sh_reg[65]};
    assign d_ge    = (d_rem >= {4'd0, den_reg});

    assign p_sat = |prod_reg[95:63];
    assign m_res = p_sat ? MAXMAG : prod_reg[62:16];
    assign d_sat = |res_reg[49:47];

    always_comb
    begin
        unique case (law_reg)
            LAW_RECIP: fac = 49'(ONE_Q16) - $signed({2'b00, q_reg});
            LAW_QUART: fac = $signed({2'b00, q4_reg}) - $signed({2'b00, q_reg});
            default:   fac = $signed({2'b00, q2_reg}) - 49'(ONE_Q16);
        endcase
    end

    assign sel_idx  = cmd.acc_sel_second ? idx2_reg : idx1_reg;
    assign in_range = (32'(sel_idx) < 32'(PARTICLE_COUNT));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            add_val[a] = cmd.acc_sel_second ? -force_reg[a] : force_reg[a];
            add_res[a] = sat_add48($signed(rd_data[a*FORCE_W +: FORCE_W]), add_val[a]);
            upd_sat[a] = add_res[a][48];
        end
        upd_data = {add_res[2][47:0], add_res[1][47:0], add_res[0][47:0]};
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(sel_idx);
        wr_data = '0;
        priority if (cmd.clr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
        end
        else if (cmd.acc_upd)
        begin
            wr_en   = in_range;
            wr_data = upd_data;
        end
        else if (cmd.acc_read_clr)
        begin
            wr_en = in_range;
        end
    end

    plsfa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (PARTICLE_COUNT)
    ) u_accum_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ADDR_W'(sel_idx)),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg       <= LAW_SQUARE;
            flag_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_wr_data != LAW_INVALID))
            begin
                law_reg <= cfg_wr_data;
            end
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.zero_flag
                || (done_reg && is_mul && (cmd.op != OP_SQ) && p_sat)
                || (done_reg && (cmd.op == OP_DIV) && d_sat)
                || (cmd.acc_upd && in_range && (|upd_sat)))
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx1_reg   <= in_idx1;
            idx2_reg   <= in_idx2;
            k_reg      <= in_k;
            l0_reg     <= in_l0;
            norm2_reg  <= '0;
            for (int a = 0; a < 3; a++)
            begin
                mag_reg[a]   <= diff_mag[a];
                dneg_reg[a]  <= diff[a][32];
                force_reg[a] <= '0;
            end
        end
        if (cmd.start)
        begin
            ma_reg   <= op_a;
            mb_reg   <= op_b;
            prod_reg <= '0;
            rem_reg  <= '0;
            res_reg  <= '0;
            if (cmd.op == OP_ROOT)
            begin
                sh_reg <= {norm2_reg, 16'd0};
            end
            else if (law_reg == LAW_RECIP)
            begin
                sh_reg  <= {2'b00, l0_reg, 32'd0};
                den_reg <= n_reg;
            end
            else
            begin
                sh_reg  <= {n_reg, 32'd0};
                den_reg <= {2'b00, l0_reg};
            end
        end
        else if (busy_reg)
        begin
            if (is_mul)
            begin
                prod_reg <= prod_reg + pp_shift;
            end
            else if (cmd.op == OP_ROOT)
            begin
                sh_reg <= {sh_reg[63:0], 2'b00};
                if (r_rem >= r_trial)
                begin
                    rem_reg <= r_rem - r_trial;
                    res_reg <= {res_reg[48:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r_rem;
                    res_reg <= {res_reg[48:0], 1'b0};
                end
            end
            else
            begin
                sh_reg  <= {sh_reg[64:0], 1'b0};
                rem_reg <= d_ge ? (d_rem - {4'd0, den_reg}) : d_rem;
                res_reg <= {res_reg[48:0], d_ge};
            end
        end
        if (done_reg)
        begin
            unique case (cmd.op)
                OP_SQ:   norm2_reg <= norm2_reg + prod_reg[65:16];
                OP_ROOT: n_reg     <= res_reg[33:0];
                OP_DIV:  q_reg     <= d_sat ? MAXMAG : res_reg[46:0];
                OP_Q2:   q2_reg    <= m_res;
                OP_Q4:   q4_reg    <= m_res;
                OP_KM:   km_reg    <= m_res;
                OP_FM:
                begin
                    force_reg[cmd.axis] <= (dneg_reg[cmd.axis] ^ fneg_reg)
                                         ? -$signed({1'b0, m_res})
                                         : $signed({1'b0, m_res});
                end
                default: n_reg <= n_reg;
            endcase
        end
        if (cmd.fac)
        begin
            fneg_reg <= fac[48];
            fm_reg   <= fac[48] ? 48'(-fac) : fac[47:0];
        end
        if (cmd.acc_read_clr)
        begin
            for (int a = 0; a < 3; a++)
            begin
                force_reg[a] <= in_range ? $signed(rd_data[a*FORCE_W +: FORCE_W]) : '0;
            end
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {7'd0, flag_reg, force_reg[2], force_reg[1], force_reg[0]};
        end
    end

    assign status.action   = in_action;
    assign status.done     = done_reg;
    assign status.zero     = (norm2_reg == '0) || (l0_reg == '0);
    assign status.law      = law_reg;
    assign status.clr_last = (clr_cnt_reg == ADDR_W'(PARTICLE_COUNT - 1));
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/power_law_spring_force_accumulator_core.sv
// Spring transaction: the result is set by the bit-serial divider (50 steps), bit-pair square root
// (33 steps) and 24x24 multiplier (4 steps per product); law 2 adds a squaring of the quotient and
// law 3 a second one. Read transaction: the entry is read and cleared, then the result is registered.
// One transaction in flight; the next is taken once the result is registered and the block is idle.
// Reset: asynchronous, active low; law 2, flag clear, then a clearing pass over all 1024 entries.
// Top level of the power-law spring force accumulator.
module power_law_spring_force_accumulator_core import plsfa_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_index, second_index, first_x/y/z, second_x/y/z, stiffness, rest_length, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // force_x, force_y, force_z, diverged, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    plsfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    plsfa_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (s_axis_tdata),
        .in_action   (s_axis_tuser[0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule
